FILE: rtl/ttem_pkg.sv
// Shared constants, codes and types for the two-tap echo mixer.
package ttem_pkg;

  localparam int MaxDelay  = 4096;
  localparam int HistDepth = 2 * MaxDelay;
  localparam int AddrW     = $clog2(HistDepth);

  localparam int SampleW   = 8;
  localparam int DelayW    = 13;
  localparam int GainW     = 16;
  localparam int SeenW     = DelayW + 1;
  localparam int ProdW     = GainW + SampleW;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 16;

  // numerators are kept in Q15 of the sample scale
  localparam int FracShift = 15;
  localparam int NumW      = ProdW + 2;
  localparam int MagW      = NumW - FracShift;

  // floor(m/3) == (m*683) >> 11 for all m < 2048
  localparam int Div3MulW  = 10;
  localparam int Div3Shift = 11;
  localparam logic [Div3MulW-1:0] Div3Mul = 10'd683;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELAY = 1'b0,
    CFG_GAIN  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_TWO   = 2'd1,
    MODE_THREE = 2'd2
  } mode_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } tag_t;

endpackage

FILE: rtl/ttem_arith.sv
// Arithmetic pipeline: tap products, numerator, magnitude, divide and saturate.
module ttem_arith (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  ttem_pkg::tag_t                       tag_i,
  input  logic signed [ttem_pkg::SampleW-1:0]  x_i,
  input  logic signed [ttem_pkg::GainW-1:0]    g_i,
  input  logic signed [ttem_pkg::SampleW-1:0]  tap1_i,
  input  logic signed [ttem_pkg::SampleW-1:0]  tap2_i,
  output logic                                 valid_o,
  output logic [ttem_pkg::SampleW-1:0]         y_o
);
  import ttem_pkg::*;

  tag_t                      tag1_r, tag2_r, tag3_r;
  logic                      valid4_r;
  logic signed [SampleW-1:0] x1_r;
  logic signed [ProdW-1:0]   p1_r, p2_r;
  logic signed [NumW-1:0]    n_r;
  logic                      neg_r;
  logic [MagW-1:0]           mag_r;
  logic [SampleW-1:0]        y_r;

  logic signed [NumW-1:0]    xs, p1s, p2s, n_nxt, abs_n;
  logic [Div3Shift+MagW-1:0] prod3;
  logic [MagW-1:0]           q;
  logic [SampleW-1:0]        y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r   <= '0;
      tag2_r   <= '0;
      tag3_r   <= '0;
      valid4_r <= 1'b0;
    end else if (en) begin
      tag1_r   <= tag_i;
      tag2_r   <= tag1_r;
      tag3_r   <= tag2_r;
      valid4_r <= tag3_r.valid;
    end
  end

  // numerator select
  always_comb begin
    xs  = NumW'(x1_r);
    p1s = NumW'(p1_r);
    p2s = NumW'(p2_r);
    case (tag1_r.mode)
      MODE_TWO:   n_nxt = (xs <<< (FracShift - 1)) + p1s;
      MODE_THREE: n_nxt = (xs <<< FracShift) + (p1s <<< 1) + p2s;
      default:    n_nxt = xs <<< FracShift;
    endcase
  end

  assign abs_n = n_r[NumW-1] ? -n_r : n_r;

  // magnitude, divide by three where needed, then sign and saturate
  always_comb begin
    prod3 = mag_r * Div3Mul;
    if (tag3_r.mode == MODE_THREE) begin
      q = prod3[Div3Shift +: MagW];
    end else begin
      q = mag_r;
    end
    if (neg_r) begin
      if (q > MagW'(128)) y_nxt = 8'h80;
      else                y_nxt = SampleW'(-q);
    end else begin
      if (q > MagW'(127)) y_nxt = 8'h7f;
      else                y_nxt = q[SampleW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= x_i;
      p1_r  <= g_i * tap1_i;
      p2_r  <= g_i * tap2_i;
      n_r   <= n_nxt;
      neg_r <= n_r[NumW-1];
      mag_r <= abs_n[NumW-1:FracShift];
      y_r   <= y_nxt;
    end
  end

  assign valid_o = valid4_r;
  assign y_o     = y_r;

endmodule

FILE: rtl/two_tap_echo_mixer_core.sv
// Two-tap echo mixer: history memories, tap addressing and stream control.
// Pipeline from input transfer to output transfer: memory read, products,
// numerator, magnitude, divide/saturate into the output register.
// Throughput: one sample per cycle unless the output stalls; both taps come from
// two mirrored history memories, each with one write and one read port per cycle.
// Reset (synchronous, rst_n low): pipeline empties, write pointer and sample
// count clear, delay becomes 1 and gain 0; history is not cleared.
module two_tap_echo_mixer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ttem_pkg::SampleW-1:0]  in_tdata,   // [7:0] sample_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ttem_pkg::SampleW-1:0]  out_tdata,  // [7:0] sample_out
  input  logic                          cfg_we,
  input  logic [ttem_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ttem_pkg::CfgDataW-1:0] cfg_wdata
);
  import ttem_pkg::*;

  logic [DelayW-1:0]  delay_r;
  logic [GainW-1:0]   gain_r;
  logic [AddrW-1:0]   wp_r;
  logic [SeenW-1:0]   seen_r;

  logic [SampleW-1:0] hist_a [HistDepth];
  logic [SampleW-1:0] hist_b [HistDepth];

  tag_t               tag0_r;
  logic [SampleW-1:0] x0_r, tap1_r, tap2_r;
  logic [GainW-1:0]   g0_r;

  logic               en, accept;
  logic [DelayW-1:0]  d_eff;
  logic [SeenW-1:0]   lim, seen_eff, seen_nxt;
  logic [AddrW-1:0]   addr1, addr2, wp_nxt;
  mode_t              mode;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && rst_n;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (delay_r == '0)                    d_eff = DelayW'(1);
    else if (delay_r > DelayW'(MaxDelay)) d_eff = DelayW'(MaxDelay);
    else                                  d_eff = delay_r;
    lim      = {d_eff, 1'b0};
    // a delay change can leave the count above the new limit
    seen_eff = (seen_r > lim) ? lim : seen_r;
    if (seen_eff < SeenW'(d_eff)) mode = MODE_PASS;
    else if (seen_eff < lim)      mode = MODE_TWO;
    else                          mode = MODE_THREE;
    seen_nxt = (seen_eff < lim) ? seen_eff + SeenW'(1) : seen_eff;
    addr1    = wp_r - d_eff[AddrW-1:0];
    addr2    = wp_r - lim[AddrW-1:0];
    wp_nxt   = (wp_r == AddrW'(HistDepth - 1)) ? '0 : wp_r + AddrW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DelayW'(1);
      gain_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DELAY: delay_r <= cfg_wdata[DelayW-1:0];
        CFG_GAIN:  gain_r  <= cfg_wdata[GainW-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      seen_r <= '0;
      tag0_r <= '0;
    end else if (en) begin
      tag0_r.valid <= accept;
      tag0_r.mode  <= mode;
      if (accept) begin
        wp_r   <= wp_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  // read-before-write: a tap two delays back may hit the slot written now
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_a[wp_r] <= in_tdata;
      tap1_r       <= hist_a[addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_b[wp_r] <= in_tdata;
      tap2_r       <= hist_b[addr2];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x0_r <= in_tdata;
      g0_r <= gain_r;
    end
  end

  ttem_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_i   (tag0_r),
    .x_i     (x0_r),
    .g_i     (g0_r),
    .tap1_i  (tap1_r),
    .tap2_i  (tap2_r),
    .valid_o (out_tvalid),
    .y_o     (out_tdata)
  );

endmodule

FILE: test/two_tap_echo_mixer_core_test.sv
// Self-checking testbench for the two-tap echo mixer core, predicting each echoed sample.
module two_tap_echo_mixer_core_test;
  import ttem_pkg::*;

  localparam int     DrainCycles  = 10;
  localparam int     FinalWaitMax = 20000;
  localparam int     TimeoutUnits = 2_000_000;
  localparam int     IdlePercent  = 31;
  localparam longint Q14          = 16384;
  localparam longint Q15          = 32768;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SampleW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SampleW-1:0]  out_tdata;
  logic                cfg_we = 1'b0;
  cfg_idx_t            cfg_index = CFG_DELAY;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  two_tap_echo_mixer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // echo state as the testbench sees it
  logic [SampleW-1:0]       hist_mem [HistDepth];
  logic [AddrW-1:0]         wr_ptr;
  int unsigned              seen_count;
  logic [DelayW-1:0]        delay_reg;
  logic signed [GainW-1:0]  gain_reg;

  logic [SampleW-1:0] expected_echo_q [$];
  int error_count = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(TimeoutUnits);
    $display("Some tests failed");
    $finish;
  end

  function automatic void reset_echo_state();
    foreach (hist_mem[i]) hist_mem[i] = '0;
    wr_ptr     = '0;
    seen_count = 0;
    delay_reg  = DelayW'(1);
    gain_reg   = '0;
  endfunction

  function automatic longint tap_sample(input int unsigned back);
    logic [AddrW-1:0] ofs;
    logic [AddrW-1:0] addr;
    ofs  = back[AddrW-1:0];
    addr = wr_ptr - ofs;
    return longint'($signed(hist_mem[addr]));
  endfunction

  function automatic logic [SampleW-1:0] predict_echo(input logic [SampleW-1:0] s);
    int unsigned d;
    int unsigned lim;
    longint x;
    longint g;
    longint y;
    d = delay_reg;
    if (d < 1) d = 1;
    if (d > MaxDelay) d = MaxDelay;
    lim = 2 * d;
    if (seen_count > lim) seen_count = lim;
    x = longint'($signed(s));
    g = longint'(gain_reg);
    if (seen_count < d)
      y = x;
    else if (seen_count < lim)
      y = (x * Q14 + g * tap_sample(d)) / (2 * Q14);
    else
      y = (x * Q15 + 2 * g * tap_sample(d) + g * tap_sample(lim)) / (3 * Q15);
    if (y > 127) y = 127;
    if (y < -128) y = -128;
    hist_mem[wr_ptr] = s;
    wr_ptr = wr_ptr + 1'b1;
    if (seen_count < lim) seen_count++;
    return y[SampleW-1:0];
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DELAY) delay_reg = val[DelayW-1:0];
    else gain_reg = val;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [SampleW-1:0] s);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    expected_echo_q.push_back(predict_echo(s));
  endtask

  // stop offering and let every outstanding transfer come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_echo_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'h7F : 8'h80;
    return SampleW'($urandom);
  endfunction

  function automatic logic [GainW-1:0] rand_gain_in_range();
    return GainW'($urandom_range(32768)) - GainW'(Q14);
  endfunction

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (no_idle || $urandom_range(99) >= IdlePercent) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [SampleW-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_echo_q.size() == 0) begin
        $error("sample_out: no transfer expected, actual %0d", $signed(out_tdata));
        error_count++;
      end else begin
        want = expected_echo_q.pop_front();
        if (out_tdata !== want) begin
          $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(out_tdata));
          error_count++;
        end
      end
    end
  end

  // reset values: delay 1, gain 0
  task automatic test_reset_defaults();
    send_sample(8'h80);
    send_sample(8'h7F);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'h01);
  endtask

  task automatic test_gain_extremes();
    drain();
    write_reg(CFG_GAIN, 16'h4000);
    write_reg(CFG_DELAY, 16'd2);
    repeat (4) send_sample(8'h7F);
    repeat (4) send_sample(8'h80);
    drain();
    write_reg(CFG_GAIN, 16'hC000);
    send_sample(8'h7F);
    send_sample(8'h80);
    send_sample(8'h7F);
    send_sample(8'h80);
  endtask

  // gain beyond +-1.0 saturates the output; delay 0 acts as 1, above the maximum acts as maximum
  task automatic test_out_of_range();
    drain();
    write_reg(CFG_GAIN, 16'h7FFF);
    write_reg(CFG_DELAY, 16'd0);
    send_sample(8'h7F);
    send_sample(8'h7F);
    send_sample(8'h80);
    drain();
    write_reg(CFG_GAIN, 16'h8000);
    write_reg(CFG_DELAY, 16'h1FFF);
    send_sample(8'h7F);
    send_sample(8'h80);
  endtask

  // delay and gain change between phases; the sample count carries over
  task automatic test_random_stream();
    logic [CfgDataW-1:0] dly;
    logic [CfgDataW-1:0] gn;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin dly = 16'd1; gn = 16'h4000; end
        1: begin dly = 16'd2; gn = 16'hC000; end
        2: begin dly = CfgDataW'($urandom_range(3, 12)); gn = rand_gain_in_range(); end
        3: begin dly = 16'd0; gn = CfgDataW'($urandom); end
        4: begin dly = CfgDataW'($urandom_range(13, 30)); gn = rand_gain_in_range(); end
        5: begin dly = CfgDataW'($urandom_range(1, 5)); gn = 16'h7FFF; end
        6: begin dly = CfgDataW'($urandom_range(15, 25)); gn = 16'h8000; end
        default: begin dly = 16'd3; gn = rand_gain_in_range(); end
      endcase
      drain();
      write_reg(CFG_DELAY, dly);
      write_reg(CFG_GAIN, gn);
      no_idle = (phase == 4);
      repeat (60) send_sample(rand_sample());
    end
    no_idle = 1'b0;
  endtask

  // receiver stalls long enough for the core to fill and block its input
  task automatic test_backpressure();
    drain();
    write_reg(CFG_DELAY, 16'd4);
    write_reg(CFG_GAIN, rand_gain_in_range());
    no_idle  = 1'b1;
    hold_req = 300;
    repeat (80) send_sample(rand_sample());
    no_idle = 1'b0;
    drain();
    repeat (30) send_sample(rand_sample());
  endtask

  // full delay: samples pass unchanged while the count is below the delay
  task automatic test_max_delay();
    drain();
    write_reg(CFG_DELAY, CfgDataW'(MaxDelay));
    write_reg(CFG_GAIN, rand_gain_in_range());
    no_idle = 1'b1;
    repeat (24) send_sample(rand_sample());
    no_idle = 1'b0;
    repeat (16) send_sample(rand_sample());
    drain();
  endtask

  initial begin
    int waited;
    reset_echo_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_gain_extremes();
    test_out_of_range();
    test_random_stream();
    test_backpressure();
    test_max_delay();
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_echo_q.size() != 0 && waited < FinalWaitMax) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (expected_echo_q.size() != 0) begin
      $error("sample_out: %0d expected transfers never arrived", expected_echo_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: two_tap_echo_mixer_core.f
rtl/ttem_pkg.sv
rtl/ttem_arith.sv
rtl/two_tap_echo_mixer_core.sv
test/two_tap_echo_mixer_core_test.sv
